@@ sv/pnms_pkg.sv @@
// ============================================================================
// pnms_pkg
// Shared types and constants for the periodic nearest-match search block.
// ============================================================================
`default_nettype none

package pnms_pkg;

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] CFG_BOX_LEN    = 2'd0;
    localparam logic [1:0] CFG_RADIUS     = 2'd1;
    localparam logic [1:0] CFG_LOG_WEIGHT = 2'd2;
    localparam logic [1:0] CFG_MASS_FRAC  = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [31:0] BOX_LEN_RST    = 32'hFFFF_FFFF;
    localparam logic [31:0] RADIUS_RST     = 32'hFFFF_FFFF;
    localparam logic [15:0] LOG_WEIGHT_RST = 16'd256;
    localparam logic [15:0] MASS_FRAC_RST  = 16'd0;

    // log10(2) in Q0.32
    localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TLOG_GO,
        S_TLOG_WAIT,
        S_RD,
        S_AXD,
        S_AXM,
        S_AXA,
        S_UNIT_GO,
        S_UNIT_WAIT,
        S_LR,
        S_TERM,
        S_SCORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       store;
        logic       q_load;
        logic       tlog_start;
        logic       tlog_save;
        logic       rd_en;
        logic       axis_d;
        logic       axis_sq;
        logic       axis_acc;
        logic [1:0] axis;
        logic       unit_start;
        logic       cut;
        logic       lr;
        logic       term;
        logic       update;
        logic       rsp_load;
    } t_dp_cmd;

    typedef struct packed {
        logic log_busy;
        logic sqrt_busy;
        logic empty;
        logic last;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ sv/pnms_if.sv @@
// ============================================================================
// pnms_if
// Request and response channel interfaces of the nearest-match search block.
// ============================================================================
`default_nettype none

interface pnms_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [11:0] entry_index;
    logic [31:0] entry_x;
    logic [31:0] entry_y;
    logic [31:0] entry_z;
    logic [31:0] entry_mass;
    logic [31:0] tgt_x;
    logic [31:0] tgt_y;
    logic [31:0] tgt_z;
    logic [31:0] tgt_mass;
    logic [12:0] group_count;

    modport source (output valid, func, entry_index, entry_x, entry_y, entry_z, entry_mass,
                    tgt_x, tgt_y, tgt_z, tgt_mass, group_count,
                    input ready);
    modport sink (input valid, func, entry_index, entry_x, entry_y, entry_z, entry_mass,
                  tgt_x, tgt_y, tgt_z, tgt_mass, group_count,
                  output ready);
endinterface

interface pnms_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [11:0] best_index;
    logic [31:0] best_score;
    logic [31:0] best_distance;

    modport source (output valid, found, best_index, best_score, best_distance,
                    input ready);
    modport sink (input valid, found, best_index, best_score, best_distance,
                  output ready);
endinterface

`default_nettype wire

@@ sv/pnms_ram.sv @@
// ============================================================================
// pnms_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module pnms_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/pnms_sqrt.sv @@
// ============================================================================
// pnms_sqrt
// Iterative 64-bit integer square root, one result bit per cycle.
// ============================================================================
`default_nettype none

module pnms_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_value,
    output logic             o_busy,
    output logic [31:0]      o_root
);

    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_v, n_v;
    logic [31:0] r_root, n_root;
    logic [32:0] r_rem, n_rem;
    logic [34:0] rem_s;
    logic [34:0] trial;

    always_comb begin
        rem_s  = {r_rem, r_v[63:62]};
        trial  = {1'b0, r_root, 2'b01};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_v    = r_v;
        n_root = r_root;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_v    = i_value;
            n_root = '0;
            n_rem  = '0;
        end else if (r_busy) begin
            n_v = {r_v[61:0], 2'b00};
            if (rem_s >= trial) begin
                n_rem  = 33'(rem_s - trial);
                n_root = {r_root[30:0], 1'b1};
            end else begin
                n_rem  = rem_s[32:0];
                n_root = {r_root[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_v    <= n_v;
        r_root <= n_root;
        r_rem  <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

@@ sv/pnms_log2.sv @@
// ============================================================================
// pnms_log2
// Iterative log2 in Q5.16: leading-one position plus one fraction bit per
// cycle by repeated squaring of a normalized mantissa.
// ============================================================================
`default_nettype none

module pnms_log2 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_value,
    output logic             o_busy,
    output logic [20:0]      o_log
);

    logic        r_busy, n_busy;
    logic [3:0]  r_cnt, n_cnt;
    logic [4:0]  r_msb, n_msb;
    logic [31:0] r_m, n_m;
    logic [15:0] r_frac, n_frac;
    logic [4:0]  msb;
    logic [63:0] sq;
    logic [32:0] t;

    always_comb begin
        msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_value[i]) begin
                msb = 5'(i);
            end
        end
    end

    always_comb begin
        sq     = 64'(r_m) * 64'(r_m);
        t      = sq[63:31];
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_msb  = r_msb;
        n_m    = r_m;
        n_frac = r_frac;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_msb  = msb;
            n_m    = i_value << (5'd31 - msb);
            n_frac = '0;
        end else if (r_busy) begin
            n_frac = {r_frac[14:0], t[32]};
            n_m    = t[32] ? t[32:1] : t[31:0];
            n_cnt  = r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_msb  <= n_msb;
        r_m    <= n_m;
        r_frac <= n_frac;
    end

    assign o_busy = r_busy;
    assign o_log  = {r_msb, r_frac};

endmodule

`default_nettype wire

@@ sv/pnms_dp.sv @@
// ============================================================================
// pnms_dp
// Datapath: catalog memory, configuration, distance and score arithmetic,
// best-match tracking and response register.
// ============================================================================
`default_nettype none

module pnms_dp import pnms_pkg::*; #(
    parameter int CATALOG_DEPTH = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts,
    input  wire logic [11:0] i_entry_index,
    input  wire logic [31:0] i_entry_x,
    input  wire logic [31:0] i_entry_y,
    input  wire logic [31:0] i_entry_z,
    input  wire logic [31:0] i_entry_mass,
    input  wire logic [31:0] i_tgt_x,
    input  wire logic [31:0] i_tgt_y,
    input  wire logic [31:0] i_tgt_z,
    input  wire logic [31:0] i_tgt_mass,
    input  wire logic [12:0] i_group_count,
    output logic             o_found,
    output logic [11:0]      o_best_index,
    output logic [31:0]      o_best_score,
    output logic [31:0]      o_best_distance
);

    localparam int AW    = (CATALOG_DEPTH > 1) ? $clog2(CATALOG_DEPTH) : 1;
    localparam int CNT_W = $clog2(CATALOG_DEPTH + 1);

    logic [31:0] r_box, r_radius;
    logic [15:0] r_weight, r_ratio;

    logic [31:0]      r_tx, r_ty, r_tz, r_tm;
    logic [CNT_W-1:0] r_count, r_idx;
    logic [47:0]      r_mass_floor;
    logic [20:0]      r_tlog;
    logic [31:0]      r_d;
    logic [63:0]      r_prod, r_sq;
    logic [31:0]      r_dist;
    logic             r_pass, r_lz;
    logic [20:0]      r_ld;
    logic [19:0]      r_lr, r_term;
    logic             r_found;
    logic [11:0]      r_best_idx;
    logic [31:0]      r_best_sc, r_best_d;
    logic             r_o_found;
    logic [11:0]      r_o_idx;
    logic [31:0]      r_o_sc, r_o_d;

    logic [16:0]  gc_ext, depth_ext, idx_in_ext, cnt_sel, cur_idx_ext;
    logic         store_ok;
    logic [127:0] rdata;
    logic [31:0]  c_x, c_y, c_z, c_mass;
    logic [31:0]  p, t, diff, d_wrap;
    logic [64:0]  acc;
    logic         log_busy, sqrt_busy;
    logic [20:0]  log_res;
    logic [31:0]  root;
    logic [51:0]  lr_prod;
    logic [35:0]  term_prod;
    logic [32:0]  score_sum;
    logic [31:0]  score;

    assign gc_ext      = {4'b0, i_group_count};
    assign depth_ext   = 17'(CATALOG_DEPTH);
    assign idx_in_ext  = {5'b0, i_entry_index};
    assign store_ok    = idx_in_ext < depth_ext;
    assign cnt_sel     = (gc_ext > depth_ext) ? depth_ext : gc_ext;
    assign cur_idx_ext = 17'(r_idx);

    pnms_ram #(
        .WIDTH (128),
        .DEPTH (CATALOG_DEPTH),
        .ADDR_W(AW)
    ) u_catalog (
        .i_clk  (i_clk),
        .i_we   (i_cmd.store && store_ok),
        .i_waddr(idx_in_ext[AW-1:0]),
        .i_wdata({i_entry_x, i_entry_y, i_entry_z, i_entry_mass}),
        .i_re   (i_cmd.rd_en),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(rdata)
    );

    assign c_x    = rdata[127:96];
    assign c_y    = rdata[95:64];
    assign c_z    = rdata[63:32];
    assign c_mass = rdata[31:0];

    pnms_log2 u_log2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.tlog_start || i_cmd.unit_start),
        .i_value(i_cmd.tlog_start ? r_tm : c_mass),
        .o_busy (log_busy),
        .o_log  (log_res)
    );

    pnms_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.unit_start),
        .i_value(r_sq),
        .o_busy (sqrt_busy),
        .o_root (root)
    );

    always_comb begin
        case (i_cmd.axis)
            AXIS_X:  begin p = c_x; t = r_tx; end
            AXIS_Y:  begin p = c_y; t = r_ty; end
            default: begin p = c_z; t = r_tz; end
        endcase
        diff = (p >= t) ? p - t : t - p;
        if ({diff, 1'b0} > {1'b0, r_box}) begin
            d_wrap = (r_box >= diff) ? r_box - diff : diff - r_box;
        end else begin
            d_wrap = diff;
        end
        acc       = {1'b0, r_sq} + {1'b0, r_prod};
        lr_prod   = 52'(r_ld) * 52'(LOG10_2_Q32);
        term_prod = 36'(r_weight) * 36'(r_lr);
        score_sum = 33'(r_dist) + 33'(r_term);
        score     = score_sum[32] ? 32'hFFFF_FFFF : score_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box    <= BOX_LEN_RST;
            r_radius <= RADIUS_RST;
            r_weight <= LOG_WEIGHT_RST;
            r_ratio  <= MASS_FRAC_RST;
            r_count  <= '0;
            r_idx    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BOX_LEN:    r_box    <= i_cfg_data;
                    CFG_RADIUS:     r_radius <= i_cfg_data;
                    CFG_LOG_WEIGHT: r_weight <= i_cfg_data[15:0];
                    CFG_MASS_FRAC:  r_ratio  <= i_cfg_data[15:0];
                    default:        ;
                endcase
            end
            if (i_cmd.q_load) begin
                r_count <= CNT_W'(cnt_sel);
                r_idx   <= '0;
            end else if (i_cmd.update) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_load) begin
            r_tx         <= i_tgt_x;
            r_ty         <= i_tgt_y;
            r_tz         <= i_tgt_z;
            r_tm         <= i_tgt_mass;
            r_mass_floor <= 48'(i_tgt_mass) * 48'(r_ratio);
            r_found      <= 1'b0;
            r_best_idx   <= '0;
            r_best_sc    <= 32'hFFFF_FFFF;
            r_best_d     <= '0;
        end
        if (i_cmd.tlog_save) begin
            r_tlog <= log_res;
        end
        if (i_cmd.rd_en) begin
            r_sq <= '0;
        end
        if (i_cmd.axis_d) begin
            r_d <= d_wrap;
        end
        if (i_cmd.axis_sq) begin
            r_prod <= 64'(r_d) * 64'(r_d);
        end
        if (i_cmd.axis_acc) begin
            r_sq <= acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
        end
        if (i_cmd.cut) begin
            r_dist <= root;
            r_pass <= (root < r_radius) && ({8'b0, c_mass, 8'b0} > r_mass_floor);
            r_ld   <= (log_res >= r_tlog) ? log_res - r_tlog : r_tlog - log_res;
            r_lz   <= (r_tm == '0) || (c_mass == '0);
        end
        if (i_cmd.lr) begin
            r_lr <= r_lz ? '0 : lr_prod[51:32];
        end
        if (i_cmd.term) begin
            r_term <= term_prod[35:16];
        end
        if (i_cmd.update && r_pass && (!r_found || score < r_best_sc)) begin
            r_found    <= 1'b1;
            r_best_idx <= cur_idx_ext[11:0];
            r_best_sc  <= score;
            r_best_d   <= r_dist;
        end
        if (i_cmd.rsp_load) begin
            r_o_found <= r_found;
            r_o_idx   <= r_best_idx;
            r_o_sc    <= r_best_sc;
            r_o_d     <= r_best_d;
        end
    end

    assign o_sts.log_busy  = log_busy;
    assign o_sts.sqrt_busy = sqrt_busy;
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.last      = (({1'b0, r_idx} + 1'b1) == {1'b0, r_count});

    assign o_found         = r_o_found;
    assign o_best_index    = r_o_idx;
    assign o_best_score    = r_o_sc;
    assign o_best_distance = r_o_d;

endmodule

`default_nettype wire

@@ sv/pnms_ctrl.sv @@
// ============================================================================
// pnms_ctrl
// Controller: sequences stores and queries over the datapath and owns the
// request ready and the response valid.
// ============================================================================
`default_nettype none

module pnms_ctrl import pnms_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    input  wire logic    i_req_func,
    output logic         o_req_ready,
    output logic         o_rsp_valid,
    input  wire logic    i_rsp_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic       r_rsp_valid, n_rsp_valid;
    logic       accept;

    assign accept = i_req_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AXIS_X;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_rsp_valid = r_rsp_valid;
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        o_req_ready = 1'b0;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (accept) begin
                    if (i_req_func == FUNC_STORE) begin
                        o_cmd.store = 1'b1;
                    end else begin
                        o_cmd.q_load = 1'b1;
                        n_state      = S_TLOG_GO;
                    end
                end
            end
            S_TLOG_GO: begin
                o_cmd.tlog_start = 1'b1;
                n_state          = S_TLOG_WAIT;
            end
            S_TLOG_WAIT: begin
                if (!i_sts.log_busy) begin
                    o_cmd.tlog_save = 1'b1;
                    n_state         = i_sts.empty ? S_DONE : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_axis      = AXIS_X;
                n_state     = S_AXD;
            end
            S_AXD: begin
                o_cmd.axis_d = 1'b1;
                n_state      = S_AXM;
            end
            S_AXM: begin
                o_cmd.axis_sq = 1'b1;
                n_state       = S_AXA;
            end
            S_AXA: begin
                o_cmd.axis_acc = 1'b1;
                if (r_axis == AXIS_Z) begin
                    n_state = S_UNIT_GO;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_AXD;
                end
            end
            S_UNIT_GO: begin
                o_cmd.unit_start = 1'b1;
                n_state          = S_UNIT_WAIT;
            end
            S_UNIT_WAIT: begin
                if (!i_sts.log_busy && !i_sts.sqrt_busy) begin
                    o_cmd.cut = 1'b1;
                    n_state   = S_LR;
                end
            end
            S_LR: begin
                o_cmd.lr = 1'b1;
                n_state  = S_TERM;
            end
            S_TERM: begin
                o_cmd.term = 1'b1;
                n_state    = S_SCORE;
            end
            S_SCORE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.last ? S_DONE : S_RD;
            end
            S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.rsp_load = 1'b1;
                    n_rsp_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

@@ sv/periodic_nearest_match_search.sv @@
// ============================================================================
// periodic_nearest_match_search
// Catalog of positioned masses with a periodic-box nearest-match query.
// ============================================================================
// A store request writes one catalog slot. A query scans slots
// 0 .. min(group_count, CATALOG_DEPTH)-1 one at a time and returns one response;
// its running time grows with the slots scanned and is set by the per-slot
// 32-step square root and the three-axis distance sequence that run through
// one shared multiplier and root unit. The response sits in an output
// register, so stores are taken while it waits to be collected.
`default_nettype none

module periodic_nearest_match_search import pnms_pkg::*; #(
    parameter int CATALOG_DEPTH = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    pnms_req_if.sink         i_req,
    pnms_rsp_if.source       o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    req_ready;
    logic    rsp_valid;

    pnms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .i_req_func (i_req.func),
        .o_req_ready(req_ready),
        .o_rsp_valid(rsp_valid),
        .i_rsp_ready(o_rsp.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    pnms_dp #(
        .CATALOG_DEPTH(CATALOG_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_entry_index  (i_req.entry_index),
        .i_entry_x      (i_req.entry_x),
        .i_entry_y      (i_req.entry_y),
        .i_entry_z      (i_req.entry_z),
        .i_entry_mass   (i_req.entry_mass),
        .i_tgt_x        (i_req.tgt_x),
        .i_tgt_y        (i_req.tgt_y),
        .i_tgt_z        (i_req.tgt_z),
        .i_tgt_mass     (i_req.tgt_mass),
        .i_group_count  (i_req.group_count),
        .o_found        (o_rsp.found),
        .o_best_index   (o_rsp.best_index),
        .o_best_score   (o_rsp.best_score),
        .o_best_distance(o_rsp.best_distance)
    );

    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;

endmodule

`default_nettype wire

@@ sv/pnms_checker.sv @@
// ============================================================================
// pnms_checker
// Port-level checks on the nearest-match search block.
// ============================================================================
`default_nettype none

module pnms_checker import pnms_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_req_func,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic        i_found,
    input wire logic [11:0] i_best_index,
    input wire logic [31:0] i_best_score,
    input wire logic [31:0] i_best_distance
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_func == FUNC_QUERY |=> !i_req_ready)
        else $error("request taken while a query runs");

    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_found |->
            i_best_index == '0 && i_best_score == 32'hFFFF_FFFF && i_best_distance == '0)
        else $error("not-found response fields wrong");

    a_score_ge_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_best_score >= i_best_distance)
        else $error("score below distance");

endmodule

bind periodic_nearest_match_search pnms_checker u_pnms_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_req_func     (i_req.func),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_found        (o_rsp.found),
    .i_best_index   (o_rsp.best_index),
    .i_best_score   (o_rsp.best_score),
    .i_best_distance(o_rsp.best_distance)
);

`default_nettype wire

@@ verif/tb_periodic_nearest_match_search.sv @@
// ============================================================================
// tb_periodic_nearest_match_search
// Self-checking bench for the periodic nearest-match search block.
// ============================================================================
// Catalog stores and queries go in through the request channel. A model of
// the catalog and registers computes each expected response when a query is
// accepted. Directed tests cover field extremes, wrapping, both cuts, ties
// and a saturated score. Random phases under several register settings then
// mix stores and queries. Both channels idle at random, with one stretch of
// no idling.
`default_nettype none

module tb_periodic_nearest_match_search;
    import pnms_pkg::*;

    localparam int DEPTH      = 4096;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic        func;
        logic [11:0] entry_index;
        logic [31:0] entry_x, entry_y, entry_z, entry_mass;
        logic [31:0] tgt_x, tgt_y, tgt_z, tgt_mass;
        logic [12:0] group_count;
    } t_request;

    typedef struct {
        logic        found;
        logic [11:0] best_index;
        logic [31:0] best_score;
        logic [31:0] best_distance;
    } t_match;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    pnms_req_if req ();
    pnms_rsp_if rsp ();

    periodic_nearest_match_search dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_req      (req.sink),
        .o_rsp      (rsp.source)
    );

    logic [31:0] cat_x [DEPTH];
    logic [31:0] cat_y [DEPTH];
    logic [31:0] cat_z [DEPTH];
    logic [31:0] cat_mass [DEPTH];
    bit          slot_written [DEPTH];
    logic [31:0] cfg_box, cfg_radius;
    logic [15:0] cfg_weight, cfg_frac;

    t_match pending_matches [$];
    int     error_count;
    int     stall_cycles;
    bit     no_idle;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] axis_square(logic [31:0] p, logic [31:0] t);
        logic [63:0] d;
        d = (p >= t) ? 64'(p - t) : 64'(t - p);
        if (2 * d > 64'(cfg_box))
            d = (64'(cfg_box) >= d) ? 64'(cfg_box) - d : d - 64'(cfg_box);
        return d * d;
    endfunction

    function automatic logic [31:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] log2_fix(logic [31:0] x);
        int          msb;
        logic [63:0] m;
        logic [15:0] frac;
        msb = 31;
        frac = 0;
        while (msb > 0 && x[msb] == 1'b0)
            msb--;
        m = 64'(x) << (31 - msb);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                frac[0] = 1'b1;
                m >>= 1;
            end
        end
        return (32'(msb) << 16) | 32'(frac);
    endfunction

    function automatic t_match search_catalog(t_request q);
        t_match      best;
        int          count;
        logic [63:0] sq, s, lr, score, ld, mass_floor;
        logic [31:0] sep, mass, lm, lt;
        best = '{1'b0, 12'd0, 32'hFFFF_FFFF, 32'd0};
        count = (q.group_count > DEPTH) ? DEPTH : int'(q.group_count);
        mass_floor = 64'(q.tgt_mass) * 64'(cfg_frac);
        for (int i = 0; i < count; i++) begin
            mass = cat_mass[i];
            sq = 0;
            for (int a = 0; a < 3; a++) begin
                s = (a == 0) ? axis_square(cat_x[i], q.tgt_x)
                  : (a == 1) ? axis_square(cat_y[i], q.tgt_y)
                  : axis_square(cat_z[i], q.tgt_z);
                sq = (sq > ~64'd0 - s) ? ~64'd0 : sq + s;
            end
            sep = int_sqrt(sq);
            if (sep >= cfg_radius || (64'(mass) << 8) <= mass_floor)
                continue;
            lr = 0;
            if (q.tgt_mass != 0 && mass != 0) begin
                lm = log2_fix(mass);
                lt = log2_fix(q.tgt_mass);
                ld = (lm >= lt) ? 64'(lm - lt) : 64'(lt - lm);
                lr = (ld * 64'd1292913986) >> 32;
            end
            score = 64'(sep) + ((64'(cfg_weight) * lr) >> 16);
            if (score > 64'hFFFF_FFFF)
                score = 64'hFFFF_FFFF;
            if (!best.found || score[31:0] < best.best_score)
                best = '{1'b1, 12'(i), score[31:0], sep};
        end
        return best;
    endfunction

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < DEPTH && slot_written[n])
            n++;
        return n;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_request(t_request r);
        while (!no_idle && $urandom_range(99) < 32) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid       <= 1'b1;
        req.func        <= r.func;
        req.entry_index <= r.entry_index;
        req.entry_x     <= r.entry_x;
        req.entry_y     <= r.entry_y;
        req.entry_z     <= r.entry_z;
        req.entry_mass  <= r.entry_mass;
        req.tgt_x       <= r.tgt_x;
        req.tgt_y       <= r.tgt_y;
        req.tgt_z       <= r.tgt_z;
        req.tgt_mass    <= r.tgt_mass;
        req.group_count <= r.group_count;
        do @(posedge i_clk); while (!req.ready);
        if (r.func == FUNC_STORE) begin
            cat_x[r.entry_index]        = r.entry_x;
            cat_y[r.entry_index]        = r.entry_y;
            cat_z[r.entry_index]        = r.entry_z;
            cat_mass[r.entry_index]     = r.entry_mass;
            slot_written[r.entry_index] = 1'b1;
        end else begin
            pending_matches.insert(pending_matches.size(), search_catalog(r));
        end
    endtask

    task automatic store_entry(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] mass);
        t_request r;
        r = '{FUNC_STORE, 12'(idx), x, y, z, mass, $urandom, $urandom, $urandom, $urandom,
              13'($urandom)};
        send_request(r);
    endtask

    task automatic run_query(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] mass, logic [12:0] count);
        t_request r;
        r = '{FUNC_QUERY, 12'($urandom), $urandom, $urandom, $urandom, $urandom,
              x, y, z, mass, count};
        send_request(r);
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [31:0] box, logic [31:0] radius, logic [15:0] weight,
                                logic [15:0] ratio);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_BOX_LEN;
        i_cfg_data <= box;
        @(posedge i_clk);
        i_cfg_index <= CFG_RADIUS;
        i_cfg_data <= radius;
        @(posedge i_clk);
        i_cfg_index <= CFG_LOG_WEIGHT;
        i_cfg_data <= {16'($urandom_range(65535)), weight};
        @(posedge i_clk);
        i_cfg_index <= CFG_MASS_FRAC;
        i_cfg_data <= {16'($urandom_range(65535)), ratio};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_box = box;
        cfg_radius = radius;
        cfg_weight = weight;
        cfg_frac = ratio;
    endtask

    function automatic logic [31:0] near(logic [31:0] c, int span);
        return ($urandom_range(3) == 0) ? $urandom : c + 32'($urandom_range(span));
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(1, 5000));
        endcase
    endfunction

    task automatic test_directed_defaults();
        store_entry(0, 32'd0, 32'd0, 32'd0, 32'd0);
        store_entry(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        store_entry(2, 32'h100, 32'h200, 32'h300, 32'd1);
        store_entry(3, 32'h100, 32'h200, 32'h300, 32'd1);
        store_entry(4, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'd1000);
        store_entry(5, 32'h10, 32'h20, 32'h30, 32'd7);
        store_entry(6, 32'h7FFF_FFFF, 32'h1, 32'h1234_5678, 32'd123456);
        store_entry(7, 32'h101, 32'h201, 32'h301, 32'd2);
        run_query(32'd0, 32'd0, 32'd0, 32'd5, 13'd0);
        run_query(32'd0, 32'd0, 32'd0, 32'd0, 13'd1);
        run_query(32'h100, 32'h200, 32'h300, 32'd1, 13'd8);
        run_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd8);
        run_query(32'h100, 32'h200, 32'h300, 32'd0, 13'd4);
    endtask

    task automatic test_box_wrap();
        program_regs(32'h1000, 32'h900, 16'd0, 16'd0);
        run_query(32'h0F00, 32'h0F00, 32'h0F00, 32'd1, 13'd8);
        run_query(32'h0, 32'h0, 32'h0, 32'd3, 13'd8);
        program_regs(32'd1, 32'hFFFF_FFFF, 16'd65535, 16'd0);
        run_query(32'h5, 32'h5, 32'h5, 32'd9, 13'd8);
    endtask

    task automatic test_cuts_and_saturation();
        program_regs(32'd2, 32'hFFFF_FFFF, 16'd65535, 16'd0);
        run_query(32'd0, 32'd0, 32'd0, 32'd1, 13'd2);
        program_regs(32'hFFFF_FFFF, 32'd0, 16'd256, 16'd0);
        run_query(32'h100, 32'h200, 32'h300, 32'd1, 13'd8);
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd256, 16'd65535);
        run_query(32'h100, 32'h200, 32'h300, 32'd1, 13'd8);
        run_query(32'h100, 32'h200, 32'h300, 32'hFFFF_FFFF, 13'd8);
        run_query(32'h100, 32'h200, 32'h300, 32'd0, 13'd8);
        program_regs(32'hFFFF_FFFF, 32'h101, 16'd256, 16'd256);
        run_query(32'h100, 32'h200, 32'h300, 32'd1, 13'd8);
    endtask

    task automatic test_random_phase(int items);
        logic [31:0] center;
        int          limit;
        center = $urandom;
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(2) == 0) begin
                store_entry(($urandom_range(7) == 0) ? $urandom_range(DEPTH - 1)
                                                      : $urandom_range(40),
                            near(center, 32'h3FFF), near(center, 32'h3FFF),
                            near(center, 32'h3FFF), pick_mass());
            end else begin
                limit = written_prefix();
                if (limit > 24)
                    limit = 24;
                run_query(near(center, 32'h3FFF), near(center, 32'h3FFF),
                          near(center, 32'h3FFF), pick_mass(), 13'($urandom_range(limit)));
            end
            if (n == items / 2)
                wait_idle();
        end
    endtask

    task automatic test_random_settings();
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd256, 16'd0);
        test_random_phase(25);
        program_regs(32'h0001_0000 + $urandom_range(32'hFFFF), 32'h3000, 16'($urandom),
                     16'($urandom_range(300)));
        test_random_phase(25);
        no_idle = 1'b1;
        program_regs($urandom, $urandom, 16'($urandom), 16'($urandom_range(512)));
        test_random_phase(20);
        no_idle = 1'b0;
        program_regs(32'h8000, 32'h6000, 16'd65535, 16'd128);
        test_random_phase(25);
        program_regs($urandom, $urandom_range(32'h2_0000), 16'($urandom), 16'($urandom));
        test_random_phase(23);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else begin
            rsp.ready <= no_idle || ($urandom_range(99) >= 32);
            if (rsp.valid && rsp.ready) begin
                if (pending_matches.size() == 0) begin
                    report("unexpected response", 32'(rsp.best_index), 32'd0);
                end else begin
                    t_match want;
                    want = pending_matches.pop_front();
                    if (rsp.found !== want.found)
                        report("found", 32'(rsp.found), 32'(want.found));
                    if (rsp.best_index !== want.best_index)
                        report("best_index", 32'(rsp.best_index), 32'(want.best_index));
                    if (rsp.best_score !== want.best_score)
                        report("best_score", rsp.best_score, want.best_score);
                    if (rsp.best_distance !== want.best_distance)
                        report("best_distance", rsp.best_distance, want.best_distance);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        stall_cycles = 0;
        no_idle = 1'b0;
        cfg_box = BOX_LEN_RST;
        cfg_radius = RADIUS_RST;
        cfg_weight = LOG_WEIGHT_RST;
        cfg_frac = MASS_FRAC_RST;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_BOX_LEN;
        i_cfg_data <= '0;
        req.valid <= 1'b0;
        req.func <= FUNC_STORE;
        req.entry_index <= '0;
        req.entry_x <= '0;
        req.entry_y <= '0;
        req.entry_z <= '0;
        req.entry_mass <= '0;
        req.tgt_x <= '0;
        req.tgt_y <= '0;
        req.tgt_z <= '0;
        req.tgt_mass <= '0;
        req.group_count <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_defaults();
        test_box_wrap();
        test_cuts_and_saturation();
        test_random_settings();
        wait_idle();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/pnms_pkg.sv
sv/pnms_if.sv
sv/pnms_ram.sv
sv/pnms_sqrt.sv
sv/pnms_log2.sv
sv/pnms_dp.sv
sv/pnms_ctrl.sv
sv/periodic_nearest_match_search.sv
sv/pnms_checker.sv
verif/tb_periodic_nearest_match_search.sv
